FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WORM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define WORM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define WORM_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define WORM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: src/worm_pkg.sv
package worm_pkg;

   localparam int RING_DEPTH_DEF = 64;

   localparam int OP_W       = 2;
   localparam int BYTES_W    = 32;
   localparam int TICK_W     = 32;
   localparam int SUM_W      = 38;
   localparam int RATE_W     = 48;
   localparam int HELD_W     = 7;
   localparam int WIN_W      = 20;
   localparam int MIN_W      = 6;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 20;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_MS   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_ENTRIES = 1'd1;

   localparam logic [WIN_W-1:0]  WINDOW_RST = 20'd40000;
   localparam logic [MIN_W-1:0]  MIN_RST    = 6'd10;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: src/worm_ram.sv
module worm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/worm_div.sv
module worm_div #(
   parameter int N_W = worm_pkg::RATE_W,
   parameter int D_W = worm_pkg::TICK_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [N_W-1:0]           dividend,
   input  logic [D_W-1:0]           divisor,
   output logic [N_W-1:0]           quotient,
   output worm_pkg::div_status_type status
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[N_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = D_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: src/windowed_overhead_rate_meter.sv
// Sliding-window byte rate meter.
// Input channel (req_*): an item carries an opcode. Add accumulates
// req_byte_count into a saturating pending counter; sample pushes the pending
// bytes stamped with req_now_ms into a ring, expires old entries and computes
// the rate; clear empties the ring and the counters. Add and clear complete in
// the idle state and give no result; sample gives exactly one result item.
// Result channel (rsp_*): rate in bytes per second, a valid flag and the
// number of ring entries held after expiry.
// Configuration (csr_*): window_ms and min_entries, written with csr_we.
// A sample steps through the states in order: a push (first a read and a drop
// of the oldest entry when the ring is full), an expiry walk that reads and
// checks each ring entry examined (every dropped entry plus the survivor, at
// most RING_DEPTH), then, when a rate is computed, the multiply, the divider
// start and a 48-step serial divide, and last the load of the output register.
// The ring memory's single read port and the one-bit-per-cycle divider set the
// pace of a sample.
// req_ready is high only while no sample is at work, so the next item is taken
// in the cycle after the result is loaded. A finished result waits in an output
// register; while it stalls, add and clear items are still taken, and a
// following sample holds at its end. Reset empties the ring and loads the
// registers with 40000 ms and 10.
`include "assert_macros.svh"

module windowed_overhead_rate_meter #(
   parameter int RING_DEPTH = worm_pkg::RING_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [worm_pkg::OP_W-1:0]           req_op,
   input  logic [worm_pkg::BYTES_W-1:0]        req_byte_count,
   input  logic [worm_pkg::TICK_W-1:0]         req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [worm_pkg::RATE_W-1:0]         rsp_rate_bytes_per_sec,
   output logic                                rsp_rate_valid,
   output logic [worm_pkg::HELD_W-1:0]         rsp_entries_held,
   input  logic                                csr_we,
   input  logic [worm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [worm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int BW     = worm_pkg::BYTES_W;
   localparam int TW     = worm_pkg::TICK_W;
   localparam int SW     = worm_pkg::SUM_W;
   localparam int RW     = worm_pkg::RATE_W;
   localparam int MEM_W  = BW + TW;
   localparam int ST_W   = 4;

   localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] S_FULL_RD  = 4'd1;
   localparam logic [ST_W-1:0] S_FULL_DRP = 4'd2;
   localparam logic [ST_W-1:0] S_PUSH     = 4'd3;
   localparam logic [ST_W-1:0] S_EXP_RD   = 4'd4;
   localparam logic [ST_W-1:0] S_EXP_CHK  = 4'd5;
   localparam logic [ST_W-1:0] S_MUL      = 4'd6;
   localparam logic [ST_W-1:0] S_DIV_GO   = 4'd7;
   localparam logic [ST_W-1:0] S_DIV_WAIT = 4'd8;
   localparam logic [ST_W-1:0] S_DONE     = 4'd9;

   logic [ST_W-1:0]               state_ff, state_in;
   logic [worm_pkg::WIN_W-1:0]    window_ff, window_in;
   logic [worm_pkg::MIN_W-1:0]    min_ff, min_in;
   logic [BW-1:0]                 pending_ff, pending_in;
   logic [IDX_W-1:0]              oldest_ff, oldest_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [SW-1:0]                 sum_ff, sum_in;
   logic [TW-1:0]                 now_ff, now_in;
   logic [TW-1:0]                 elapsed_ff, elapsed_in;
   logic [SW-1:0]                 num_ff, num_in;
   logic [RW-1:0]                 prod_ff, prod_in;
   logic [RW-1:0]                 res_rate_ff, res_rate_in;
   logic                          res_ok_ff, res_ok_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]                 rsp_rate_ff, rsp_rate_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic [worm_pkg::HELD_W-1:0]   rsp_held_ff, rsp_held_in;

   logic [BW:0]                   add_sum;
   logic [IDX_W:0]                slot_sum;
   logic [IDX_W-1:0]              slot;
   logic [IDX_W-1:0]              oldest_next;
   logic                          mem_we;
   logic                          mem_re;
   logic [MEM_W-1:0]              mem_rd;
   logic [BW-1:0]                 rd_bytes;
   logic [TW-1:0]                 rd_time;
   logic [TW-1:0]                 age;
   logic                          req_take;
   logic [RW-1:0]                 quotient;
   worm_pkg::div_status_type      div_stat;

   assign req_take  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign add_sum   = {1'b0, pending_ff} + {1'b0, req_byte_count};
   assign slot_sum  = (IDX_W+1)'(oldest_ff) + (IDX_W+1)'(count_ff[IDX_W-1:0]);
   assign slot      = (slot_sum >= (IDX_W+1)'(RING_DEPTH))
                      ? IDX_W'(slot_sum - (IDX_W+1)'(RING_DEPTH))
                      : slot_sum[IDX_W-1:0];
   assign oldest_next = (oldest_ff == IDX_W'(RING_DEPTH - 1)) ? '0
                        : oldest_ff + IDX_W'(1);
   assign rd_bytes  = mem_rd[MEM_W-1:TW];
   assign rd_time   = mem_rd[TW-1:0];
   assign age       = now_ff - rd_time;
   assign mem_we    = (state_ff == S_PUSH);
   assign mem_re    = (state_ff == S_FULL_RD) || (state_ff == S_EXP_RD);

   worm_ram #(
      .WIDTH (MEM_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (slot),
      .wr_data ({pending_ff, now_ff}),
      .rd_en   (mem_re),
      .rd_addr (oldest_ff),
      .rd_data (mem_rd)
   );

   worm_div #(
      .N_W (RW),
      .D_W (TW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV_GO),
      .dividend (prod_ff),
      .divisor  (elapsed_ff),
      .quotient (quotient),
      .status   (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      min_in       = min_ff;
      pending_in   = pending_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      num_in       = num_ff;
      prod_in      = prod_ff;
      res_rate_in  = res_rate_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rate_in  = rsp_rate_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_held_in  = rsp_held_ff;

      if (csr_we) begin
         unique case (csr_addr)
            worm_pkg::CSR_WINDOW_MS:   window_in = csr_wdata[worm_pkg::WIN_W-1:0];
            worm_pkg::CSR_MIN_ENTRIES: min_in    = csr_wdata[worm_pkg::MIN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               unique case (req_op)
                  worm_pkg::OP_ADD: begin
                     pending_in = add_sum[BW] ? '1 : add_sum[BW-1:0];
                  end
                  worm_pkg::OP_SAMPLE: begin
                     now_in   = req_now_ms;
                     state_in = (count_ff == CNT_W'(RING_DEPTH)) ? S_FULL_RD : S_PUSH;
                  end
                  worm_pkg::OP_CLEAR: begin
                     pending_in = '0;
                     oldest_in  = '0;
                     count_in   = '0;
                     sum_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_FULL_RD: begin
            state_in = S_FULL_DRP;
         end
         S_FULL_DRP: begin
            sum_in    = sum_ff - SW'(rd_bytes);
            oldest_in = oldest_next;
            count_in  = count_ff - CNT_W'(1);
            state_in  = S_PUSH;
         end
         S_PUSH: begin
            sum_in     = sum_ff + SW'(pending_ff);
            count_in   = count_ff + CNT_W'(1);
            pending_in = '0;
            state_in   = S_EXP_RD;
         end
         S_EXP_RD: begin
            state_in = S_EXP_CHK;
         end
         S_EXP_CHK: begin
            if (age > TW'(window_ff)) begin
               sum_in    = sum_ff - SW'(rd_bytes);
               oldest_in = oldest_next;
               count_in  = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  res_rate_in = '0;
                  res_ok_in   = 1'b0;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_EXP_RD;
               end
            end else if ((32'(count_ff) > 32'(min_ff)) && (age != '0)) begin
               num_in     = sum_ff - SW'(rd_bytes);
               elapsed_in = age;
               state_in   = S_MUL;
            end else begin
               res_rate_in = '0;
               res_ok_in   = 1'b0;
               state_in    = S_DONE;
            end
         end
         S_MUL: begin
            // times 1000 as 1024 - 32 + 8
            prod_in  = (RW'(num_ff) << 10) - (RW'(num_ff) << 5) + (RW'(num_ff) << 3);
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               res_rate_in = quotient;
               res_ok_in   = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = res_rate_ff;
               rsp_ok_in    = res_ok_ff;
               rsp_held_in  = worm_pkg::HELD_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= worm_pkg::WINDOW_RST;
         min_ff       <= worm_pkg::MIN_RST;
         pending_ff   <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         min_ff       <= min_in;
         pending_ff   <= pending_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      elapsed_ff  <= elapsed_in;
      num_ff      <= num_in;
      prod_ff     <= prod_in;
      res_rate_ff <= res_rate_in;
      res_ok_ff   <= res_ok_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_held_ff <= rsp_held_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_rate_bytes_per_sec = rsp_rate_ff;
   assign rsp_rate_valid         = rsp_ok_ff;
   assign rsp_entries_held       = rsp_held_ff;

   `WORM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(RING_DEPTH))
   `WORM_ASSERT_IMP(a_oldest_bound, clock, reset, 1'b1, oldest_ff <= IDX_W'(RING_DEPTH - 1))
   `WORM_ASSERT_IMP(a_div_in_wait, clock, reset, div_stat.busy, state_ff == S_DIV_WAIT)
   `WORM_ASSERT_IMP(a_rate_needs_ok, clock, reset, rsp_valid && (rsp_rate_ff != '0), rsp_ok_ff)
   `WORM_ASSERT_NXT(a_push_holds, clock, reset, state_ff == S_PUSH, count_ff != '0)

endmodule

FILE: tb/sv/tb_windowed_overhead_rate_meter.sv
`timescale 1ns / 100ps

module tb_windowed_overhead_rate_meter;

   localparam int OP_W       = worm_pkg::OP_W;
   localparam int BYTES_W    = worm_pkg::BYTES_W;
   localparam int TICK_W     = worm_pkg::TICK_W;
   localparam int RATE_W     = worm_pkg::RATE_W;
   localparam int HELD_W     = worm_pkg::HELD_W;
   localparam int SUM_W      = worm_pkg::SUM_W;
   localparam int WIN_W      = worm_pkg::WIN_W;
   localparam int MIN_W      = worm_pkg::MIN_W;
   localparam int CSR_ADDR_W = worm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = worm_pkg::CSR_DATA_W;

   localparam int DEPTH          = worm_pkg::RING_DEPTH_DEF;
   localparam int DRAIN_CYCLES   = 2 * DEPTH + 72;
   localparam int HOLD_CYCLES    = 2000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int N_PHASES = 8;
   localparam int PH_WINDOW     [N_PHASES] = '{600000, 1, 524287, 40000, 1000, 600000, 40000,
                                              300000};
   localparam int PH_MIN        [N_PHASES] = '{0, 0, 63, 10, 3, 1, 5, 32};
   localparam int PH_SEND_IDLE  [N_PHASES] = '{0, 0, 0, 70, 0, 13, 0, 70};
   localparam int PH_RECV_STALL [N_PHASES] = '{0, 0, 0, 0, 70, 13, 0, 70};
   localparam int PH_ITEMS      [N_PHASES] = '{300, 80, 350, 250, 250, 250, 200, 200};
   localparam int PH_CLEAR_PCT  [N_PHASES] = '{1, 2, 0, 1, 1, 1, 1, 1};
   localparam int PH_JUMP_PCT   [N_PHASES] = '{20, 20, 2, 20, 20, 20, 20, 20};
   localparam int PH_STEP_DIV   [N_PHASES] = '{24, 24, 128, 24, 24, 24, 24, 64};
   localparam int PH_HOLD       [N_PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0};

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [BYTES_W-1:0] byte_count;
      logic [TICK_W-1:0]  now_ms;
   } meter_cmd_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic              valid;
      logic [HELD_W-1:0] held;
   } rate_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op = worm_pkg::OP_ADD;
   logic [BYTES_W-1:0]    req_byte_count = '0;
   logic [TICK_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RATE_W-1:0]     rsp_rate_bytes_per_sec;
   logic                  rsp_rate_valid;
   logic [HELD_W-1:0]     rsp_entries_held;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = worm_pkg::CSR_WINDOW_MS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   meter_cmd_type   cmd_q [$];
   rate_result_type rate_expect_q [$];
   meter_cmd_type   next_cmd;
   rate_result_type want;

   int items_queued = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int rates_seen = 0;
   int full_ring_seen = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int          clear_pct = 0;
   int          tick_jump_pct = 0;
   int unsigned tick_step_max = 1;
   int unsigned tick_window = 40000;
   logic [TICK_W-1:0] stim_tick = '0;

   // predictor state
   logic [WIN_W-1:0]   cfg_window = worm_pkg::WINDOW_RST;
   logic [MIN_W-1:0]   cfg_min = worm_pkg::MIN_RST;
   logic [BYTES_W-1:0] meter_pending;
   logic [BYTES_W-1:0] meter_ring_bytes [DEPTH];
   logic [TICK_W-1:0]  meter_ring_tick [DEPTH];
   int                 meter_oldest;
   int                 meter_count;
   logic [SUM_W-1:0]   meter_sum;

   windowed_overhead_rate_meter DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_op                 (req_op),
      .req_byte_count         (req_byte_count),
      .req_now_ms             (req_now_ms),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_rate_bytes_per_sec (rsp_rate_bytes_per_sec),
      .rsp_rate_valid         (rsp_rate_valid),
      .rsp_entries_held       (rsp_entries_held),
      .csr_we                 (csr_we),
      .csr_addr               (csr_addr),
      .csr_wdata              (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic void meter_clear();
      meter_pending = '0;
      for (int i = 0; i < DEPTH; i++) begin
         meter_ring_bytes[i] = '0;
         meter_ring_tick[i] = '0;
      end
      meter_oldest = 0;
      meter_count = 0;
      meter_sum = '0;
   endfunction

   function automatic void meter_drop_oldest();
      if (meter_count != 0) begin
         meter_sum = meter_sum - meter_ring_bytes[meter_oldest];
         meter_oldest = (meter_oldest + 1) % DEPTH;
         meter_count--;
      end
   endfunction

   task automatic predict_meter(input logic [OP_W-1:0] op, input logic [BYTES_W-1:0] bytes,
                                input logic [TICK_W-1:0] tick);
      logic [BYTES_W:0]  acc;
      logic [TICK_W-1:0] age;
      logic [SUM_W-1:0]  num;
      logic [63:0]       quot;
      int                slot;
      rate_result_type   res;
      case (op)
         worm_pkg::OP_ADD: begin
            acc = {1'b0, meter_pending} + {1'b0, bytes};
            meter_pending = acc[BYTES_W] ? '1 : acc[BYTES_W-1:0];
         end
         worm_pkg::OP_CLEAR: begin
            meter_clear();
         end
         worm_pkg::OP_SAMPLE: begin
            if (meter_count >= DEPTH)
               meter_drop_oldest();
            slot = (meter_oldest + meter_count) % DEPTH;
            meter_ring_bytes[slot] = meter_pending;
            meter_ring_tick[slot] = tick;
            meter_count++;
            meter_sum = meter_sum + meter_pending;
            meter_pending = '0;
            // expire entries older than the window
            age = tick - meter_ring_tick[meter_oldest];
            while (meter_count != 0 && age > cfg_window) begin
               meter_drop_oldest();
               age = tick - meter_ring_tick[meter_oldest];
            end
            res.rate = '0;
            res.valid = 1'b0;
            res.held = HELD_W'(meter_count);
            if (meter_count > cfg_min && age != 0) begin
               num = meter_sum - meter_ring_bytes[meter_oldest];
               quot = ({26'd0, num} * 64'd1000) / {32'd0, age};
               res.rate = quot[RATE_W-1:0];
               res.valid = 1'b1;
            end
            rate_expect_q.insert(rate_expect_q.size(), res);
         end
         default: begin
         end
      endcase
   endtask

   task automatic push_cmd(input logic [OP_W-1:0] op, input logic [BYTES_W-1:0] bytes,
                           input logic [TICK_W-1:0] tick);
      meter_cmd_type c;
      c.op = op;
      c.byte_count = bytes;
      c.now_ms = tick;
      cmd_q.insert(cmd_q.size(), c);
      items_queued++;
   endtask

   function automatic logic [BYTES_W-1:0] pick_bytes();
      case ($urandom_range(3))
         0: return $urandom_range(0, 1500);
         1: return $urandom;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(0, 1 << 20);
      endcase
   endfunction

   function automatic logic [TICK_W-1:0] next_tick();
      if ($urandom_range(99) >= tick_jump_pct) begin
         if ($urandom_range(9) != 0)
            stim_tick = stim_tick + $urandom_range(1, tick_step_max);
      end else begin
         case ($urandom_range(3))
            0: stim_tick = stim_tick + tick_window + $urandom_range(1, 1000);
            1: stim_tick = stim_tick - $urandom_range(1, 1 << 20);
            2: stim_tick = 32'hFFFF_FFFF - $urandom_range(0, tick_step_max);
            default: stim_tick = $urandom;
         endcase
      end
      return stim_tick;
   endfunction

   task automatic queue_random(input int count);
      int made;
      int r;
      made = 0;
      while (made < count) begin
         r = $urandom_range(99);
         if (r < clear_pct) begin
            push_cmd(worm_pkg::OP_CLEAR, $urandom, $urandom);
            made++;
         end else if (r < clear_pct + 2) begin
            push_cmd(OP_UNUSED, $urandom, $urandom);
         end else if (r < 45) begin
            push_cmd(worm_pkg::OP_ADD, pick_bytes(), $urandom);
            made++;
         end else begin
            push_cmd(worm_pkg::OP_SAMPLE, $urandom, next_tick());
            made++;
         end
      end
   endtask

   task automatic write_meter_config(input int window, input int min_held);
      csr_we <= 1'b1;
      csr_addr <= worm_pkg::CSR_WINDOW_MS;
      csr_wdata <= CSR_DATA_W'(window);
      @(posedge clock);
      csr_addr <= worm_pkg::CSR_MIN_ENTRIES;
      csr_wdata <= CSR_DATA_W'(min_held);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_window = WIN_W'(window);
      cfg_min = MIN_W'(min_held);
   endtask

   task automatic wait_meter_idle();
      while (items_accepted != items_queued)
         @(posedge clock);
      while (rate_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         meter_clear();
      end else begin
         if (req_valid && req_ready) begin
            predict_meter(req_op, req_byte_count, req_now_ms);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = cmd_q[0];
               cmd_q.delete(0);
               req_valid <= 1'b1;
               req_op <= next_cmd.op;
               req_byte_count <= next_cmd.byte_count;
               req_now_ms <= next_cmd.now_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rate_expect_q.size() == 0) begin
               $display("%0t: result with no sample waiting: rate %0d valid %0d held %0d",
                        $time, rsp_rate_bytes_per_sec, rsp_rate_valid, rsp_entries_held);
               mismatches++;
            end else begin
               want = rate_expect_q[0];
               rate_expect_q.delete(0);
               if (rsp_rate_bytes_per_sec !== want.rate) begin
                  $display("%0t: rate mismatch: expected %0d, got %0d",
                           $time, want.rate, rsp_rate_bytes_per_sec);
                  mismatches++;
               end
               if (rsp_rate_valid !== want.valid) begin
                  $display("%0t: rate_valid mismatch: expected %0d, got %0d",
                           $time, want.valid, rsp_rate_valid);
                  mismatches++;
               end
               if (rsp_entries_held !== want.held) begin
                  $display("%0t: entries_held mismatch: expected %0d, got %0d",
                           $time, want.held, rsp_entries_held);
                  mismatches++;
               end
               results_checked++;
               if (want.valid)
                  rates_seen++;
               if (want.held == DEPTH)
                  full_ring_seen++;
            end
         end
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("** windowed_overhead_rate_meter: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed items at the reset register values
      push_cmd(worm_pkg::OP_SAMPLE, '0, '0);
      push_cmd(worm_pkg::OP_ADD, '0, '1);
      push_cmd(worm_pkg::OP_ADD, '1, '0);
      push_cmd(worm_pkg::OP_ADD, 32'd7, '0);
      push_cmd(worm_pkg::OP_SAMPLE, '0, 32'hFFFF_FFF0);
      push_cmd(worm_pkg::OP_SAMPLE, '1, 32'hFFFF_FFF0);
      push_cmd(worm_pkg::OP_ADD, 32'h8000_0000, '0);
      push_cmd(worm_pkg::OP_SAMPLE, '0, 32'h0000_0010);
      push_cmd(OP_UNUSED, '1, '1);
      push_cmd(worm_pkg::OP_SAMPLE, '0, 32'd39984);
      push_cmd(worm_pkg::OP_SAMPLE, '0, 32'd39985);
      push_cmd(worm_pkg::OP_SAMPLE, '0, 32'd5);
      push_cmd(worm_pkg::OP_CLEAR, '1, '1);
      push_cmd(worm_pkg::OP_ADD, 32'h5555_AAAA, '0);
      push_cmd(worm_pkg::OP_SAMPLE, '0, '1);
      wait_meter_idle();

      for (int ph = 0; ph < N_PHASES; ph++) begin
         write_meter_config(PH_WINDOW[ph], PH_MIN[ph]);
         send_idle_pct = PH_SEND_IDLE[ph];
         recv_stall_pct = PH_RECV_STALL[ph];
         clear_pct = PH_CLEAR_PCT[ph];
         tick_jump_pct = PH_JUMP_PCT[ph];
         tick_window = PH_WINDOW[ph];
         tick_step_max = (PH_WINDOW[ph] / PH_STEP_DIV[ph] > 0) ?
                         PH_WINDOW[ph] / PH_STEP_DIV[ph] : 1;
         queue_random(PH_ITEMS[ph]);
         if (PH_HOLD[ph] != 0)
            hold_requests++;
         wait_meter_idle();
      end

      $display("Run covered %0d items over %0d register settings: %0d samples checked,",
               items_accepted, N_PHASES + 1, results_checked);
      $display("%0d of them with a rate and %0d with a full ring.", rates_seen,
               full_ring_seen);
      if (mismatches == 0) begin
         $display("** windowed_overhead_rate_meter: PASSED **");
      end else begin
         $display("** windowed_overhead_rate_meter: FAILED **");
      end
      $finish;
   end

endmodule
